>>> design/srtf_pkg.sv
// shared types and constants of the srtf tick scheduler
package srtf_pkg;

	localparam int DEFAULT_MAX_PROCESSES = 16;
	localparam int DATA_W  = 16;
	localparam int SLOT_W  = 4;
	localparam int CMD_W   = 2;
	localparam int COUNT_W = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD    = 2'd0,
		CMD_TICK    = 2'd1,
		CMD_RESTART = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [SLOT_W-1:0] slot;
		logic [DATA_W-1:0] arrival_time;
		logic [DATA_W-1:0] burst_time;
	} cmd_word_t;

	typedef struct packed {
		logic [SLOT_W-1:0] running_slot;
		logic              busy_res;
		logic              finished;
		logic [SLOT_W-1:0] finished_slot;
		logic [DATA_W-1:0] wait_time;
		logic [DATA_W-1:0] turnaround_time;
	} res_word_t;

	// one entry of the slot memory
	typedef struct packed {
		logic [DATA_W-1:0] arrival;
		logic [DATA_W-1:0] burst;
	} slot_entry_t;

endpackage

>>> design/srtf_if.sv
// valid/ready channels for command and result words
interface srtf_cmd_if;
	import srtf_pkg::*;
	logic      valid;
	logic      ready;
	cmd_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface srtf_res_if;
	import srtf_pkg::*;
	logic      valid;
	logic      ready;
	res_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> design/srtf_tick_scheduler_top.sv
// srtf tick scheduler: slot memories, scan sequencer and result register
// load and no-op words: EMIT registers the result when free, next word taken after it
// tick: update, then a scan reading one slot per cycle over the slots in use
// restart: the sweep copies burst into remaining time
// one word at a time; the result register lets the next word in while a result waits
// arst_n clears time, running slot and count, sets every done mark; memories are not reset
module srtf_tick_scheduler_top #(
	parameter int MAX_PROCESSES = srtf_pkg::DEFAULT_MAX_PROCESSES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [srtf_pkg::COUNT_W-1:0] cfg_wdata,
	srtf_cmd_if.sink                     cmd,
	srtf_res_if.source                   res
);
	import srtf_pkg::*;

	localparam int IDX_W  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
	localparam int NCNT_W = $clog2(MAX_PROCESSES + 1);
	localparam int CNT_W  = (NCNT_W > COUNT_W) ? NCNT_W : COUNT_W;
	localparam int SW     = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_UPD   = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_SWEEP = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t state_q;

	logic [COUNT_W-1:0]       pc_q;
	logic [DATA_W-1:0]        time_q;
	logic [IDX_W-1:0]         cur_slot_q;
	logic [MAX_PROCESSES-1:0] done_q;

	// slot memories
	slot_entry_t       ab_mem [MAX_PROCESSES];
	logic [DATA_W-1:0] rem_mem [MAX_PROCESSES];
	slot_entry_t       ab_rd_q;
	logic [DATA_W-1:0] rem_rd_q;

	// scan engine
	logic [CNT_W-1:0]  rd_i_q;
	logic              vld_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              found_q;
	logic [IDX_W-1:0]  best_q;
	logic [DATA_W-1:0] best_rem_q;
	logic [DATA_W-1:0] best_arr_q;

	// per-word results
	logic              busy_q;
	logic              fin_q;
	logic [IDX_W-1:0]  fslot_q;
	logic [DATA_W-1:0] wait_q;
	logic [DATA_W-1:0] tat_q;

	logic      out_valid_q;
	res_word_t out_q;

	logic [CNT_W-1:0]  n_slots;
	logic [CNT_W-1:0]  pc_ext;
	logic              accept;
	logic [IDX_W-1:0]  rd_addr;
	logic              scan_issue;
	logic [SW-1:0]     load_slot_ext;
	logic              load_ok;
	logic              ab_we;
	logic              rem_we;
	logic [IDX_W-1:0]  rem_waddr;
	logic [DATA_W-1:0] rem_wdata;
	logic              cur_elig;
	logic              served;
	logic              fin;
	logic [DATA_W-1:0] completion;
	logic [DATA_W-1:0] tat;
	logic [DATA_W-1:0] wait_v;
	logic              tick_elig;
	logic              tick_better;
	logic              sweep_better;
	logic              out_free;
	logic [SW-1:0]     cur_ext;
	logic [SW-1:0]     fslot_ext;

	assign pc_ext  = CNT_W'(pc_q);
	assign n_slots = (pc_ext > CNT_W'(MAX_PROCESSES)) ? CNT_W'(MAX_PROCESSES) : pc_ext;

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign out_free  = !out_valid_q || res.ready;

	assign res.valid = out_valid_q;
	assign res.data  = out_q;

	assign load_slot_ext = SW'(cmd.data.slot);
	assign load_ok       = cmd.data.slot < MAX_PROCESSES;
	assign ab_we         = accept && (cmd.data.command == CMD_LOAD) && load_ok;

	assign rd_addr    = (state_q == ST_IDLE) ? cur_slot_q : rd_i_q[IDX_W-1:0];
	assign scan_issue = rd_i_q < n_slots;

	// update of the running slot
	assign cur_elig   = (CNT_W'(cur_slot_q) < n_slots) && !done_q[cur_slot_q]
	                    && (ab_rd_q.arrival <= time_q);
	assign served     = cur_elig && (rem_rd_q != '0);
	assign fin        = cur_elig && (rem_rd_q <= DATA_W'(1));
	assign completion = (time_q == '1) ? time_q : time_q + 1'b1;
	assign tat        = (completion > ab_rd_q.arrival) ? completion - ab_rd_q.arrival : '0;
	assign wait_v     = (tat > ab_rd_q.burst) ? tat - ab_rd_q.burst : '0;

	// selection over the scanned entry
	assign tick_elig    = !done_q[idx_s1] && (ab_rd_q.arrival <= time_q);
	assign tick_better  = !found_q || (rem_rd_q < best_rem_q)
	                      || ((rem_rd_q == best_rem_q) && (ab_rd_q.arrival < best_arr_q));
	assign sweep_better = !found_q || (ab_rd_q.arrival < best_arr_q);

	always_comb begin
		rem_we    = 1'b0;
		rem_waddr = cur_slot_q;
		rem_wdata = rem_rd_q - 1'b1;
		if (state_q == ST_UPD) begin
			rem_we = served;
		end else if (state_q == ST_SWEEP) begin
			rem_we    = vld_s1;
			rem_waddr = idx_s1;
			rem_wdata = ab_rd_q.burst;
		end
	end

	assign cur_ext   = SW'(cur_slot_q);
	assign fslot_ext = SW'(fslot_q);

	always_ff @(posedge clk) begin
		if (ab_we) begin
			ab_mem[load_slot_ext[IDX_W-1:0]] <= '{arrival: cmd.data.arrival_time,
			                                      burst: cmd.data.burst_time};
		end
		ab_rd_q <= ab_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (rem_we) begin
			rem_mem[rem_waddr] <= rem_wdata;
		end
		rem_rd_q <= rem_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else if (cfg_we) begin
			pc_q <= cfg_wdata;
		end
	end

	// a new result word may replace one taken on the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			time_q      <= '0;
			cur_slot_q  <= '0;
			done_q      <= '1;
			rd_i_q      <= '0;
			vld_s1      <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						busy_q  <= 1'b0;
						fin_q   <= 1'b0;
						fslot_q <= '0;
						wait_q  <= '0;
						tat_q   <= '0;
						rd_i_q  <= '0;
						vld_s1  <= 1'b0;
						found_q <= 1'b0;
						if (cmd.data.command == CMD_TICK) begin
							state_q <= ST_UPD;
						end else if (cmd.data.command == CMD_RESTART) begin
							time_q <= '0;
							for (int i = 0; i < MAX_PROCESSES; i++) begin
								done_q[i] <= !(CNT_W'(i) < n_slots);
							end
							state_q <= ST_SWEEP;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_UPD: begin
					busy_q  <= served;
					fin_q   <= fin;
					fslot_q <= fin ? cur_slot_q : '0;
					wait_q  <= fin ? wait_v : '0;
					tat_q   <= fin ? tat : '0;
					if (fin) begin
						done_q[cur_slot_q] <= 1'b1;
					end
					time_q <= completion;
					// scan starts after the update state so the write-back is visible
					state_q <= ST_SCAN;
				end
				ST_SCAN, ST_SWEEP: begin
					vld_s1 <= scan_issue;
					idx_s1 <= rd_i_q[IDX_W-1:0];
					if (scan_issue) begin
						rd_i_q <= rd_i_q + 1'b1;
					end
					if (vld_s1) begin
						if (state_q == ST_SCAN) begin
							if (tick_elig && tick_better) begin
								found_q    <= 1'b1;
								best_q     <= idx_s1;
								best_rem_q <= rem_rd_q;
								best_arr_q <= ab_rd_q.arrival;
							end
						end else if (sweep_better) begin
							found_q    <= 1'b1;
							best_q     <= idx_s1;
							best_arr_q <= ab_rd_q.arrival;
						end
					end
					if (!scan_issue && !vld_s1) begin
						if (found_q) begin
							cur_slot_q <= best_q;
						end else if (state_q == ST_SWEEP) begin
							cur_slot_q <= '0;
						end
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result word payload
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			out_q.running_slot    <= cur_ext[SLOT_W-1:0];
			out_q.busy_res        <= busy_q;
			out_q.finished        <= fin_q;
			out_q.finished_slot   <= fslot_ext[SLOT_W-1:0];
			out_q.wait_time       <= wait_q;
			out_q.turnaround_time <= tat_q;
		end
	end

endmodule

>>> sim/tb_srtf_tick_scheduler_top.sv
// self-checking testbench of the srtf tick scheduler with a scoreboard class
module tb_srtf_tick_scheduler_top;
	timeunit 1ns;
	timeprecision 1ps;
	import srtf_pkg::*;

	localparam int SLOTS        = DEFAULT_MAX_PROCESSES;
	localparam int TARGET_WORDS = 950;
	localparam int IDLE_LIMIT   = 1000;
	localparam int TAIL_CYCLES  = 50;
	localparam int MAX_REPORTS  = 40;

	class srtf_scoreboard;
		logic [DATA_W-1:0]  arrival_tab [SLOTS];
		logic [DATA_W-1:0]  burst_tab   [SLOTS];
		logic [DATA_W-1:0]  remain_tab  [SLOTS];
		bit                 done_tab    [SLOTS];
		logic [DATA_W-1:0]  now;
		logic [SLOT_W-1:0]  running;
		logic [COUNT_W-1:0] slot_count;
		res_word_t          due_results[$];
		int                 errors;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				arrival_tab[i] = '0;
				burst_tab[i]   = '0;
				remain_tab[i]  = '0;
				done_tab[i]    = 1'b1;
			end
			now        = '0;
			running    = '0;
			slot_count = '0;
			errors     = 0;
		endfunction

		function void set_count(logic [COUNT_W-1:0] v);
			slot_count = v;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		// one command word against the scheduler state, giving its result word
		function res_word_t schedule_step(cmd_word_t w);
			res_word_t r;
			int        in_use;
			int        pick;
			int        run;
			int        completion;
			int        tat;
			bit        found;
			r      = '0;
			in_use = (slot_count > SLOTS) ? SLOTS : slot_count;
			case (w.command)
				CMD_LOAD: begin
					arrival_tab[w.slot] = w.arrival_time;
					burst_tab[w.slot]   = w.burst_time;
				end
				CMD_RESTART: begin
					pick = 0;
					now  = '0;
					for (int i = 0; i < SLOTS; i++) begin
						if (i < in_use) begin
							done_tab[i]   = 1'b0;
							remain_tab[i] = burst_tab[i];
							if (arrival_tab[i] < arrival_tab[pick])
								pick = i;
						end else begin
							done_tab[i] = 1'b1;
						end
					end
					running = SLOT_W'(pick);
				end
				CMD_TICK: begin
					run        = running;
					completion = (now < 16'hFFFF) ? now + 1 : now;
					if (run < in_use && !done_tab[run] && arrival_tab[run] <= now) begin
						if (remain_tab[run] > 0) begin
							remain_tab[run] = remain_tab[run] - 1'b1;
							r.busy_res      = 1'b1;
						end
						if (remain_tab[run] == 0) begin
							done_tab[run]     = 1'b1;
							r.finished        = 1'b1;
							r.finished_slot   = SLOT_W'(run);
							tat = (completion > arrival_tab[run]) ?
								completion - arrival_tab[run] : 0;
							r.turnaround_time = DATA_W'(tat);
							// a burst reloaded after restart can exceed the turnaround
							r.wait_time = (tat > burst_tab[run]) ?
								DATA_W'(tat - burst_tab[run]) : '0;
						end
					end
					now   = DATA_W'(completion);
					found = 1'b0;
					pick  = 0;
					for (int i = 0; i < in_use; i++) begin
						if (done_tab[i] || arrival_tab[i] > now)
							continue;
						if (!found || remain_tab[i] < remain_tab[pick] ||
						    (remain_tab[i] == remain_tab[pick] &&
						     arrival_tab[i] < arrival_tab[pick])) begin
							pick  = i;
							found = 1'b1;
						end
					end
					if (found)
						running = SLOT_W'(pick);
				end
				default: ;
			endcase
			r.running_slot = running;
			return r;
		endfunction

		function void note_command(cmd_word_t w);
			due_results.push_back(schedule_step(w));
		endfunction

		function void compare_field(string name, logic [DATA_W-1:0] want,
		                            logic [DATA_W-1:0] got);
			if (got !== want) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$error("%s: expected %0d, actual %0d", name, want, got);
			end
		endfunction

		function void check_result(res_word_t got);
			res_word_t want;
			if (due_results.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$error("result word %h with nothing expected", got);
				return;
			end
			want = due_results.pop_front();
			compare_field("running_slot", DATA_W'(want.running_slot),
			              DATA_W'(got.running_slot));
			compare_field("busy_res", DATA_W'(want.busy_res), DATA_W'(got.busy_res));
			compare_field("finished", DATA_W'(want.finished), DATA_W'(got.finished));
			compare_field("finished_slot", DATA_W'(want.finished_slot),
			              DATA_W'(got.finished_slot));
			compare_field("wait_time", want.wait_time, got.wait_time);
			compare_field("turnaround_time", want.turnaround_time, got.turnaround_time);
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [COUNT_W-1:0] cfg_wdata;

	srtf_cmd_if cmd_ch ();
	srtf_res_if res_ch ();

	srtf_tick_scheduler_top #(
		.MAX_PROCESSES(SLOTS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd_ch),
		.res      (res_ch)
	);

	srtf_scoreboard sb;
	bit             calm;
	int             burst_left;
	int             sent_words;
	int             quiet;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// acceptance happens on the rising edge; the watchdog counts edges with no word moved
	always @(posedge clk) begin
		if (cmd_ch.valid && cmd_ch.ready)
			sb.note_command(cmd_ch.data);
		if (res_ch.valid && res_ch.ready)
			sb.check_result(res_ch.data);
		if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// result side stalls in runs of its own
	initial begin
		int stall;
		stall        = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (calm) begin
				res_ch.ready <= 1'b1;
			end else if (stall > 0) begin
				res_ch.ready <= 1'b0;
				stall--;
			end else if ($urandom_range(0, 5) == 0) begin
				stall        = $urandom_range(0, 15);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_word(input cmd_t op, input logic [SLOT_W-1:0] s,
	                         input logic [DATA_W-1:0] arr, input logic [DATA_W-1:0] bst);
		cmd_word_t w;
		w.command      = op;
		w.slot         = s;
		w.arrival_time = arr;
		w.burst_time   = bst;
		if (!calm && burst_left == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = $urandom_range(1, 16);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data  <= w;
		do @(posedge clk); while (!cmd_ch.ready);
		@(negedge clk);
		if (burst_left > 0)
			burst_left--;
		if (op != CMD_NOP)
			sent_words++;
	endtask

	// drops valid and waits on falling edges until no result is pending, also when none is pending at the call
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
	endtask

	task automatic program_count(input logic [COUNT_W-1:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_count(v);
	endtask

	initial begin
		logic [COUNT_W-1:0] count_sel;
		int                 in_use;
		int                 span;
		int                 late;
		int                 phase;
		sb           = new();
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data  = '0;
		calm         = 1'b1;
		burst_left   = 0;
		sent_words   = 0;
		quiet        = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// nothing in use yet: tick and restart keep slot 0
		send_word(CMD_TICK, '0, '0, '0);
		send_word(CMD_RESTART, '0, '0, '0);
		send_word(CMD_NOP, 4'hF, 16'hFFFF, 16'hFFFF);
		// every slot gets written before any can be read
		for (int i = 0; i < SLOTS; i++) begin
			if (i == 0)
				send_word(CMD_LOAD, SLOT_W'(i), '0, '0);
			else if (i == SLOTS - 1)
				send_word(CMD_LOAD, SLOT_W'(i), 16'hFFFF, 16'hFFFF);
			else
				send_word(CMD_LOAD, SLOT_W'(i), DATA_W'(i % 4), DATA_W'(1 + i % 3));
		end
		program_count(COUNT_W'(SLOTS));
		send_word(CMD_RESTART, '0, '0, '0);
		// zero burst finishes unserved; slot 1 then gets a larger burst reloaded while it has time left
		send_word(CMD_TICK, '0, '0, '0);
		send_word(CMD_LOAD, 4'd1, 16'd1, 16'd40000);
		repeat (6) send_word(CMD_TICK, '0, '0, '0);

		phase = 0;
		while (sent_words < TARGET_WORDS) begin
			calm = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0:       count_sel = '0;
				1:       count_sel = 5'd1;
				2:       count_sel = COUNT_W'(SLOTS);
				3:       count_sel = COUNT_W'($urandom_range(SLOTS + 1, 31));
				default: count_sel = COUNT_W'($urandom_range(2, 8));
			endcase
			program_count(count_sel);
			in_use = (count_sel > SLOTS) ? SLOTS : count_sel;
			// mostly short jobs so that processes really complete
			for (int i = 0; i < in_use; i++) begin
				if ($urandom_range(0, 7) == 0)
					send_word(CMD_LOAD, SLOT_W'(i), DATA_W'($urandom_range(0, 16'hFFFF)),
					          DATA_W'($urandom_range(0, 16'hFFFF)));
				else if ($urandom_range(0, 3) != 0)
					send_word(CMD_LOAD, SLOT_W'(i), DATA_W'($urandom_range(0, 15)),
					          DATA_W'($urandom_range(0, 6)));
			end
			send_word(CMD_RESTART, '0, '0, '0);
			span = 3;
			late = 0;
			for (int i = 0; i < in_use; i++) begin
				span += sb.burst_tab[i];
				if (sb.arrival_tab[i] > late)
					late = sb.arrival_tab[i];
			end
			span += late;
			if (span > 80)
				span = 80;
			for (int t = 0; t < span; t++) begin
				if (t == span / 2 && (phase == 0 || $urandom_range(0, 2) == 0))
					drain();
				if ($urandom_range(0, 11) == 0)
					send_word(cmd_t'($urandom_range(0, 3)), SLOT_W'($urandom_range(0, 15)),
					          DATA_W'($urandom_range(0, 15)), DATA_W'($urandom_range(0, 6)));
				else if ($urandom_range(0, 23) == 0)
					send_word(CMD_LOAD, SLOT_W'($urandom_range(0, 15)),
					          DATA_W'($urandom_range(0, 16'hFFFF)),
					          DATA_W'($urandom_range(0, 16'hFFFF)));
				else
					send_word(CMD_TICK, '0, '0, '0);
			end
			phase++;
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
